### sv/dq_pkg.sv
package dq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned OPCODE_W       = 3;
  localparam int unsigned STATUS_W       = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // apply the captured operation
  } cmd_t;

endpackage

### sv/dq_req_if.sv
interface dq_req_if
  import dq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) ();

  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [DATA_WIDTH-1:0] data_in;

  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);

endinterface

### sv/dq_rsp_if.sv
interface dq_rsp_if
  import dq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned COUNT_W    = $clog2(DEPTH_DEF + 1)
) ();

  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data_out;
  logic [STATUS_W-1:0]   status;
  logic [COUNT_W-1:0]    count;
  logic                  is_empty;

  modport source (output valid, output data_out, output status, output count,
                  output is_empty, input ready);
  modport sink   (input valid, input data_out, input status, input count,
                  input is_empty, output ready);

endinterface

### sv/dq_ram.sv
module dq_ram
  import dq_pkg::*;
#(
  parameter int unsigned WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/dq_ctrl.sv
module dq_ctrl
  import dq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### sv/dq_datapath.sv
module dq_datapath
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [OPCODE_W-1:0]   opcode_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [CW-1:0]         count_o,
  output logic                  is_empty_o
);

  localparam int unsigned SW = CW + 1;

  op_e                   op_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  status_e               status_q, status_d;
  logic                  rd_q;

  logic                  full, empty;
  logic [AW-1:0]         head_dec, head_inc, tail_slot, last_slot;
  logic [SW-1:0]         tail_sum, last_sum;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] rdata;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

  // head + count stays below 2*DEPTH, so one conditional subtract wraps it
  assign tail_sum  = SW'(head_q) + SW'(count_q);
  assign last_sum  = tail_sum - SW'(1);
  assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign last_slot = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = ST_OK;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = head_dec;
    raddr    = head_q;
    case (op_q)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = head_dec;
          head_d  = head_dec;
          count_d = count_q + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = tail_slot;
          count_d = count_q + CW'(1);
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = head_q;
          if (op_q == OP_POP_FRONT) begin
            head_d  = head_inc;
            count_d = count_q - CW'(1);
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = last_slot;
          if (op_q == OP_POP_BACK) begin
            count_d = count_q - CW'(1);
          end
        end
      end
      default: begin
        // unused opcodes leave head and count as is and report ok
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(opcode_i);
      data_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      status_q <= ST_OK;
      rd_q     <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
      rd_q     <= re;
    end
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec & we),
    .waddr_i (waddr),
    .wdata_i (data_q),
    .re_i    (cmd_i.exec & re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign data_o     = rd_q ? rdata : '0;
  assign status_o   = status_q;
  assign count_o    = count_q;
  assign is_empty_o = (count_q == '0);

endmodule

### sv/double_ended_queue.sv
// Bounded deque of DEPTH words in a circular store with a head pointer and an
// element count. Each request item carries an opcode (push front/back, pop
// front/back, peek front/back) and a data word, and gives exactly one response
// item with the popped or peeked word, a status (ok, empty, full), the count
// after the operation and an empty flag. One item is in flight at a time: the
// controller goes from accept to execute to respond, where the response holds
// valid until it is taken, and the next request is accepted the cycle after
// the response is taken, so no new request is taken before the last is answered.
// The controller's accept, execute and respond states set this; the execute
// cycle covers the registered read port of the store memory. The store needs
// no clearing after reset; only live entries are read.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t                  cmd;
  logic [DATA_WIDTH-1:0] data_out;
  logic [STATUS_W-1:0]   status;
  logic [CW-1:0]         count;
  logic                  is_empty;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .opcode_i   (req_i.opcode),
    .data_i     (req_i.data_in),
    .data_o     (data_out),
    .status_o   (status),
    .count_o    (count),
    .is_empty_o (is_empty)
  );

  assign rsp_o.data_out = data_out;
  assign rsp_o.status   = status;
  assign rsp_o.count    = count;
  assign rsp_o.is_empty = is_empty;

endmodule
